// ----- rtl/core/tqs_pkg.sv -----
// ----------------------------------------------------------------------------
// tqs_pkg
// Shared types and codes for the task queue quantum scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package tqs_pkg;

    // Field widths fixed by the command and result formats
    localparam int ID_W   = 8;
    localparam int TIME_W = 16;
    localparam int STAT_W = 2;

    // Command codes
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] STATUS_ADDED = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_RAN   = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_POLICY  = 1'b0;
    localparam logic CFG_QUANTUM = 1'b1;

    // Selection policy codes
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_SJF  = 1'b1;

    localparam logic [TIME_W-1:0] QUANTUM_RESET = 16'd10;

    // One table entry
    typedef struct packed {
        logic [ID_W-1:0]   task_id;
        logic [TIME_W-1:0] rem_time;
    } t_entry;

    // Operation broadcast to all cells
    typedef enum logic [1:0] {
        OP_NONE,
        OP_ADD,
        OP_UPDATE,
        OP_REMOVE
    } t_op;

    typedef struct packed {
        t_op    op;
        t_entry entry;
    } t_cell_cmd;

    // Controller state
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC
    } t_state;

    // Controller to datapath controls
    typedef struct packed {
        logic in_ready;
        logic exec;
    } t_ctrl;

endpackage

`default_nettype wire

// ----- rtl/core/tqs_in_if.sv -----
// ----------------------------------------------------------------------------
// tqs_in_if
// Command channel: valid/ready handshake with command, task id and duration.
// ----------------------------------------------------------------------------
`default_nettype none

interface tqs_in_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [tqs_pkg::ID_W-1:0]    task_id;
    logic [tqs_pkg::TIME_W-1:0]  duration;

    modport source (output valid, output command, output task_id, output duration,
                    input ready);
    modport sink   (input valid, input command, input task_id, input duration,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/core/tqs_out_if.sv -----
// ----------------------------------------------------------------------------
// tqs_out_if
// Result channel: valid/ready handshake with status and run information.
// ----------------------------------------------------------------------------
`default_nettype none

interface tqs_out_if;
    logic                        valid;
    logic                        ready;
    logic [tqs_pkg::STAT_W-1:0]  status;
    logic [tqs_pkg::ID_W-1:0]    run_id;
    logic [tqs_pkg::TIME_W-1:0]  remaining;
    logic                        completed;

    modport source (output valid, output status, output run_id, output remaining,
                    output completed, input ready);
    modport sink   (input valid, input status, input run_id, input remaining,
                    input completed, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/tqs_cfg_if.sv -----
// ----------------------------------------------------------------------------
// tqs_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
`default_nettype none

interface tqs_cfg_if;
    logic                        valid;
    logic                        ready;
    logic                        index;
    logic [tqs_pkg::TIME_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/task_queue_quantum_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// task_queue_quantum_scheduler_unit
// Bounded task table in arrival order, stored in a chain of cells. Adds
// tasks, and on a step runs the oldest task or the one with the least
// remaining time for one quantum, removing it when it completes.
//
//   Channel      Dir  Transaction contents
//   i_cmd_chan   in   command, task_id, duration
//   o_res_chan   out  status, run_id, remaining, completed
//   i_cfg_chan   in   index (0 policy_mode, 1 quantum), data
//
// One command at a time. An add, or any step in oldest-first mode, goes from
// the idle state straight to the execute state; any step in shortest-first
// mode, an empty table included, first waits in the scan state for the
// minimum wave to cross the cell chain.
// Synchronous active-low reset empties the table and restores the registers.
// A result waits in the output register; a stalled result holds only the
// execute step of the next command. Configuration writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module task_queue_quantum_scheduler_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    tqs_in_if.sink     i_cmd_chan,
    tqs_out_if.source  o_res_chan,
    tqs_cfg_if.sink    i_cfg_chan
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH+1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

    // Configuration registers
    logic                          r_policy;
    logic [tqs_pkg::TIME_W-1:0]    r_quantum;

    // Latched command
    logic                          r_cmd;
    tqs_pkg::t_entry               r_new;

    // Table occupancy
    logic [CNT_W-1:0]              r_count;
    logic [CNT_W-1:0]              n_count;

    // Output register
    logic                          r_out_valid;
    logic [tqs_pkg::STAT_W-1:0]    r_status;
    logic [tqs_pkg::ID_W-1:0]      r_run_id;
    logic [tqs_pkg::TIME_W-1:0]    r_remaining;
    logic                          r_completed;
    logic [tqs_pkg::STAT_W-1:0]    n_status;
    logic [tqs_pkg::ID_W-1:0]      n_run_id;
    logic [tqs_pkg::TIME_W-1:0]    n_remaining;
    logic                          n_completed;

    tqs_pkg::t_ctrl                ctrl;
    logic                          out_free;
    logic                          in_fire;

    // Cell chain wiring
    tqs_pkg::t_entry               w_entry    [TABLE_DEPTH];
    tqs_pkg::t_entry               w_wave     [TABLE_DEPTH];
    logic [IDX_W-1:0]              w_wave_idx [TABLE_DEPTH];
    tqs_pkg::t_cell_cmd            cell_cmd;
    logic [IDX_W-1:0]              cell_sel;

    // Selected task
    tqs_pkg::t_entry               sel_entry;
    logic [IDX_W-1:0]              sel_idx;
    logic [tqs_pkg::TIME_W-1:0]    sel_left;

    assign out_free = !r_out_valid || o_res_chan.ready;
    assign in_fire  = i_cmd_chan.valid && ctrl.in_ready;

    // Configuration writes
    assign i_cfg_chan.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy  <= tqs_pkg::POLICY_FIFO;
            r_quantum <= tqs_pkg::QUANTUM_RESET;
        end else if (i_cfg_chan.valid) begin
            unique case (i_cfg_chan.index)
                tqs_pkg::CFG_POLICY:  r_policy  <= i_cfg_chan.data[0];
                tqs_pkg::CFG_QUANTUM: r_quantum <= i_cfg_chan.data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer
    tqs_ctrl #(
        .DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd_chan.valid),
        .i_command  (i_cmd_chan.command),
        .i_policy   (r_policy),
        .i_out_free (out_free),
        .o_ctrl     (ctrl)
    );

    assign i_cmd_chan.ready = ctrl.in_ready;

    // Capture the accepted command
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd          <= i_cmd_chan.command;
            r_new.task_id  <= i_cmd_chan.task_id;
            r_new.rem_time <= i_cmd_chan.duration;
        end
    end

    // Cell chain
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        tqs_pkg::t_entry    wave_in;
        logic [IDX_W-1:0]   wave_idx_in;
        tqs_pkg::t_entry    next_in;

        if (g == 0) begin : g_head
            assign wave_in     = '0;
            assign wave_idx_in = '0;
        end else begin : g_body
            assign wave_in     = w_wave[g-1];
            assign wave_idx_in = w_wave_idx[g-1];
        end

        if (g == TABLE_DEPTH - 1) begin : g_tail
            assign next_in = w_entry[g];
        end else begin : g_mid
            assign next_in = w_entry[g+1];
        end

        tqs_cell #(
            .DEPTH    (TABLE_DEPTH),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_cmd      (cell_cmd),
            .i_sel      (cell_sel),
            .i_count    (r_count),
            .i_next     (next_in),
            .i_wave     (wave_in),
            .i_wave_idx (wave_idx_in),
            .o_entry    (w_entry[g]),
            .o_wave     (w_wave[g]),
            .o_wave_idx (w_wave_idx[g])
        );
    end

    // Task selection: head of table, or the minimum at the end of the wave
    always_comb begin
        if (r_policy == tqs_pkg::POLICY_SJF) begin
            sel_entry = w_wave[TABLE_DEPTH-1];
            sel_idx   = w_wave_idx[TABLE_DEPTH-1];
        end else begin
            sel_entry = w_entry[0];
            sel_idx   = '0;
        end
    end

    assign sel_left = sel_entry.rem_time - r_quantum;

    // Execute: table operation and result
    always_comb begin
        cell_cmd.op    = tqs_pkg::OP_NONE;
        cell_cmd.entry = r_new;
        cell_sel       = sel_idx;
        n_count        = r_count;
        n_status       = tqs_pkg::STATUS_ADDED;
        n_run_id       = '0;
        n_remaining    = '0;
        n_completed    = 1'b0;
        if (r_cmd == tqs_pkg::CMD_ADD) begin
            cell_sel = r_count[IDX_W-1:0];
            if (r_count == FULL_CNT) begin
                n_status = tqs_pkg::STATUS_FULL;
            end else begin
                cell_cmd.op = tqs_pkg::OP_ADD;
                n_count     = r_count + 1'b1;
            end
        end else if (r_count == '0) begin
            n_status = tqs_pkg::STATUS_EMPTY;
        end else begin
            n_status = tqs_pkg::STATUS_RAN;
            n_run_id = sel_entry.task_id;
            if (sel_entry.rem_time > r_quantum) begin
                cell_cmd.op             = tqs_pkg::OP_UPDATE;
                cell_cmd.entry.task_id  = sel_entry.task_id;
                cell_cmd.entry.rem_time = sel_left;
                n_remaining             = sel_left;
            end else begin
                cell_cmd.op = tqs_pkg::OP_REMOVE;
                n_count     = r_count - 1'b1;
                n_completed = 1'b1;
            end
        end
        if (!ctrl.exec) begin
            cell_cmd.op = tqs_pkg::OP_NONE;
            n_count     = r_count;
        end
    end

    // Occupancy and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (ctrl.exec) begin
                r_out_valid <= 1'b1;
            end else if (o_res_chan.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (ctrl.exec) begin
            r_status    <= n_status;
            r_run_id    <= n_run_id;
            r_remaining <= n_remaining;
            r_completed <= n_completed;
        end
    end

    assign o_res_chan.valid     = r_out_valid;
    assign o_res_chan.status    = r_status;
    assign o_res_chan.run_id    = r_run_id;
    assign o_res_chan.remaining = r_remaining;
    assign o_res_chan.completed = r_completed;

endmodule

`default_nettype wire

// ----- rtl/core/tqs_cell.sv -----
// ----------------------------------------------------------------------------
// tqs_cell
// One table slot. Holds a task entry, applies broadcast add/update/remove
// operations, and forms one stage of the running-minimum wave that moves
// down the chain one cell per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tqs_cell #(
    parameter int DEPTH    = 16,
    parameter int CELL_IDX = 0
) (
    input  wire                         i_clk,
    input  wire tqs_pkg::t_cell_cmd     i_cmd,
    input  wire [$clog2(DEPTH)-1:0]     i_sel,
    input  wire [$clog2(DEPTH+1)-1:0]   i_count,
    input  wire tqs_pkg::t_entry        i_next,
    input  wire tqs_pkg::t_entry        i_wave,
    input  wire [$clog2(DEPTH)-1:0]     i_wave_idx,
    output tqs_pkg::t_entry             o_entry,
    output tqs_pkg::t_entry             o_wave,
    output logic [$clog2(DEPTH)-1:0]    o_wave_idx
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);
    localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(CELL_IDX);
    localparam logic [CNT_W-1:0] MY_CNT   = CNT_W'(CELL_IDX);
    localparam bit               IS_FIRST = (CELL_IDX == 0);
    localparam bit               IS_LAST  = (CELL_IDX == DEPTH - 1);

    tqs_pkg::t_entry        r_entry;
    tqs_pkg::t_entry        r_wave;
    logic [IDX_W-1:0]       r_wave_idx;
    logic                   take_own;

    // Entry storage: write on add/update at this slot, close up on remove
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            tqs_pkg::OP_ADD, tqs_pkg::OP_UPDATE: begin
                if (i_sel == MY_IDX) begin
                    r_entry <= i_cmd.entry;
                end
            end
            tqs_pkg::OP_REMOVE: begin
                if (!IS_LAST && (MY_IDX >= i_sel)) begin
                    r_entry <= i_next;
                end
            end
            default: begin
            end
        endcase
    end

    // Minimum wave stage; strict compare keeps the earlier entry on a tie
    assign take_own = IS_FIRST ||
                      ((MY_CNT < i_count) && (r_entry.rem_time < i_wave.rem_time));

    always_ff @(posedge i_clk) begin
        if (take_own) begin
            r_wave     <= r_entry;
            r_wave_idx <= MY_IDX;
        end else begin
            r_wave     <= i_wave;
            r_wave_idx <= i_wave_idx;
        end
    end

    assign o_entry    = r_entry;
    assign o_wave     = r_wave;
    assign o_wave_idx = r_wave_idx;

endmodule

`default_nettype wire

// ----- rtl/core/tqs_ctrl.sv -----
// ----------------------------------------------------------------------------
// tqs_ctrl
// Command sequencer: accepts a command, waits for the minimum wave to cross
// the chain on a shortest-first step, then executes when the result
// register can take the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tqs_ctrl #(
    parameter int DEPTH = 16
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    input  wire             i_command,
    input  wire             i_policy,
    input  wire             i_out_free,
    output tqs_pkg::t_ctrl  o_ctrl
);

    localparam int CW = $clog2(DEPTH);
    localparam logic [CW-1:0] SCAN_LAST = CW'(DEPTH - 1);

    tqs_pkg::t_state r_state;
    tqs_pkg::t_state n_state;
    logic [CW-1:0]   r_scan_cnt;
    logic [CW-1:0]   n_scan_cnt;

    // State and scan counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tqs_pkg::ST_IDLE;
            r_scan_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_scan_cnt <= n_scan_cnt;
        end
    end

    // Next state
    always_comb begin
        n_state    = r_state;
        n_scan_cnt = '0;
        unique case (r_state)
            tqs_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_command == tqs_pkg::CMD_STEP && i_policy == tqs_pkg::POLICY_SJF) begin
                        n_state = tqs_pkg::ST_SCAN;
                    end else begin
                        n_state = tqs_pkg::ST_EXEC;
                    end
                end
            end
            tqs_pkg::ST_SCAN: begin
                n_scan_cnt = r_scan_cnt + 1'b1;
                if (r_scan_cnt == SCAN_LAST) begin
                    n_state    = tqs_pkg::ST_EXEC;
                    n_scan_cnt = '0;
                end
            end
            tqs_pkg::ST_EXEC: begin
                if (i_out_free) begin
                    n_state = tqs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tqs_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_ctrl.in_ready = (r_state == tqs_pkg::ST_IDLE);
        o_ctrl.exec     = (r_state == tqs_pkg::ST_EXEC) && i_out_free;
    end

endmodule

`default_nettype wire

// ----- bench/tb_task_queue_quantum_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// tb_task_queue_quantum_scheduler_unit
// Self-checking bench for the quantum scheduler. A behavioral copy of the task
// table predicts one result per accepted command, and a monitor compares every
// result transaction against the oldest prediction, field by field. Directed
// cases hit the empty and full table, zero durations, ties and a zero quantum.
// Random phases follow under several policy and quantum settings, with idle
// bursts on both channels.
// ----------------------------------------------------------------------------
module tb_task_queue_quantum_scheduler_unit;

    localparam int DEPTH       = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = DEPTH + 4;
    localparam int ID_W        = tqs_pkg::ID_W;
    localparam int TIME_W      = tqs_pkg::TIME_W;
    localparam int STAT_W      = tqs_pkg::STAT_W;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   run_id;
        logic [TIME_W-1:0] remaining;
        logic              completed;
    } t_sched_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tqs_in_if  cmd_if ();
    tqs_out_if res_if ();
    tqs_cfg_if cfg_if ();

    task_queue_quantum_scheduler_unit #(
        .TABLE_DEPTH (DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_chan (cmd_if),
        .o_res_chan (res_if),
        .i_cfg_chan (cfg_if)
    );

    always #5 i_clk = ~i_clk;

    // Predicted task table and registers
    logic [ID_W-1:0]   table_ids   [DEPTH];
    logic [TIME_W-1:0] table_times [DEPTH];
    int                table_count = 0;
    logic              cur_policy  = tqs_pkg::POLICY_FIFO;
    logic [TIME_W-1:0] cur_quantum = tqs_pkg::QUANTUM_RESET;

    t_sched_result pending_results[$];
    t_sched_result oldest_expected;

    bit          quiet_run = 1'b0;
    int unsigned mismatches = 0;
    int unsigned n_added = 0, n_full = 0, n_ran = 0, n_done = 0, n_empty = 0;
    int unsigned n_settings = 0;

    // Apply one command to the predicted table and return its result
    function automatic t_sched_result schedule_outcome(input logic cmd,
                                                       input logic [ID_W-1:0] id,
                                                       input logic [TIME_W-1:0] dur);
        t_sched_result r;
        int            pick;
        r    = '0;
        pick = 0;
        if (cmd == tqs_pkg::CMD_ADD) begin
            if (table_count >= DEPTH) begin
                r.status = tqs_pkg::STATUS_FULL;
            end else begin
                table_ids[table_count]   = id;
                table_times[table_count] = dur;
                table_count++;
                r.status = tqs_pkg::STATUS_ADDED;
            end
        end else if (table_count == 0) begin
            r.status = tqs_pkg::STATUS_EMPTY;
        end else begin
            // shortest-first: strict less-than keeps the earliest on a tie
            if (cur_policy == tqs_pkg::POLICY_SJF) begin
                for (int k = 1; k < table_count; k++)
                    if (table_times[k] < table_times[pick]) pick = k;
            end
            r.status = tqs_pkg::STATUS_RAN;
            r.run_id = table_ids[pick];
            if (table_times[pick] > cur_quantum) begin
                table_times[pick] = table_times[pick] - cur_quantum;
                r.remaining       = table_times[pick];
            end else begin
                for (int k = pick; k < table_count - 1; k++) begin
                    table_ids[k]   = table_ids[k + 1];
                    table_times[k] = table_times[k + 1];
                end
                table_count--;
                r.completed = 1'b1;
            end
        end
        return r;
    endfunction

    // Send one command transaction, with an optional idle burst ahead of it
    task automatic send_command(input logic cmd, input logic [ID_W-1:0] id,
                                input logic [TIME_W-1:0] dur);
        int gap;
        gap = 0;
        if (!quiet_run && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 19);
        if (gap > 0) begin
            @(negedge i_clk);
            cmd_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        cmd_if.valid    <= 1'b1;
        cmd_if.command  <= cmd;
        cmd_if.task_id  <= id;
        cmd_if.duration <= dur;
        do @(posedge i_clk); while (!(cmd_if.valid && cmd_if.ready));
        pending_results.push_back(schedule_outcome(cmd, id, dur));
    endtask

    // Hold the command channel until every predicted result has come back
    task automatic finish_pending();
        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [TIME_W-1:0] data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        if (idx == tqs_pkg::CFG_POLICY) cur_policy = data[0];
        else cur_quantum = data;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Registers change only once the block has gone idle
    task automatic apply_settings(input logic policy, input logic [TIME_W-1:0] q);
        finish_pending();
        repeat (SETTLE) @(posedge i_clk);
        write_register(tqs_pkg::CFG_POLICY, {{(TIME_W-1){1'b0}}, policy});
        write_register(tqs_pkg::CFG_QUANTUM, q);
        n_settings++;
    endtask

    function automatic logic [TIME_W-1:0] random_duration();
        int kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0:       return '0;
            1:       return '1;
            2, 3:    return TIME_W'($urandom_range(0, 65535));
            default: return TIME_W'($urandom_range(0, 60));
        endcase
    endfunction

    // Reset defaults: empty step, extreme ids and durations, oldest-first order
    task automatic test_empty_and_limits();
        send_command(tqs_pkg::CMD_STEP, 8'h00, 16'h0000);
        send_command(tqs_pkg::CMD_ADD, 8'h00, 16'h0000);
        send_command(tqs_pkg::CMD_ADD, 8'hFF, 16'hFFFF);
        send_command(tqs_pkg::CMD_ADD, 8'hA5, 16'd10);
        send_command(tqs_pkg::CMD_STEP, 8'hFF, 16'hFFFF);   // zero-duration task completes
        send_command(tqs_pkg::CMD_STEP, 8'h00, 16'h0000);   // oldest runs, quantum taken off
    endtask

    // Fill every slot, then one add too many
    task automatic test_fill_to_capacity();
        logic [TIME_W-1:0] dur;
        for (int k = 0; k < DEPTH - 2; k++) begin
            case (k % 3)
                0:       dur = 16'd10;              // ties with the earlier entry
                1:       dur = 16'h5555 + TIME_W'(k);
                default: dur = 16'hAAAA;
            endcase
            send_command(tqs_pkg::CMD_ADD, ID_W'(k * 17 + 3), dur);
        end
        send_command(tqs_pkg::CMD_ADD, 8'h77, 16'h1234);
    endtask

    // Shortest-first with several equal minimum times
    task automatic test_shortest_first_ties();
        apply_settings(tqs_pkg::POLICY_SJF, 16'd10);
        repeat (3) send_command(tqs_pkg::CMD_STEP, 8'h00, 16'h0000);
        send_command(tqs_pkg::CMD_ADD, 8'h5A, 16'd7);
    endtask

    // Zero quantum: only a zero remaining time can complete
    task automatic test_zero_quantum();
        apply_settings(tqs_pkg::POLICY_SJF, 16'd0);
        send_command(tqs_pkg::CMD_ADD, 8'h3C, 16'd0);
        send_command(tqs_pkg::CMD_STEP, 8'h00, 16'h0000);
        send_command(tqs_pkg::CMD_STEP, 8'h00, 16'h0000);
        apply_settings(tqs_pkg::POLICY_FIFO, 16'd0);
        send_command(tqs_pkg::CMD_STEP, 8'h00, 16'h0000);
    endtask

    task automatic run_random_phase(input logic policy, input logic [TIME_W-1:0] q,
                                    input int add_pct, input int count);
        logic cmd;
        apply_settings(policy, q);
        for (int n = 0; n < count; n++) begin
            cmd = ($urandom_range(0, 99) < add_pct) ? tqs_pkg::CMD_ADD : tqs_pkg::CMD_STEP;
            send_command(cmd, ID_W'($urandom_range(0, 255)), random_duration());
            // sender holds off until the result queue is empty
            if (n % 40 == 39) finish_pending();
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(tqs_pkg::POLICY_FIFO, 16'd1, 60, 60);
        run_random_phase(tqs_pkg::POLICY_SJF, 16'hFFFF, 55, 60);
        run_random_phase(tqs_pkg::POLICY_FIFO, TIME_W'($urandom_range(2, 40)), 50, 70);
        run_random_phase(tqs_pkg::POLICY_SJF, TIME_W'($urandom_range(1, 20)), 65, 70);
        run_random_phase(tqs_pkg::POLICY_FIFO, TIME_W'($urandom_range(1, 65535)), 40, 60);
        run_random_phase(tqs_pkg::POLICY_SJF, 16'd3, 50, 60);
    endtask

    // Closing stretch with no idling on either channel
    task automatic test_quiet_tail();
        finish_pending();
        quiet_run = 1'b1;
        run_random_phase(tqs_pkg::POLICY_SJF, tqs_pkg::QUANTUM_RESET, 50, 70);
    endtask

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transaction: status %0d id %0d",
                         $time, res_if.status, res_if.run_id);
                $display("%0t:   rem %0d done %0d", $time, res_if.remaining,
                         res_if.completed);
                mismatches++;
            end else begin
                oldest_expected = pending_results.pop_front();
                if (res_if.status !== oldest_expected.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, oldest_expected.status, res_if.status);
                    mismatches++;
                end
                if (res_if.run_id !== oldest_expected.run_id) begin
                    $display("%0t: run_id mismatch: expected 0x%02h, actual 0x%02h",
                             $time, oldest_expected.run_id, res_if.run_id);
                    mismatches++;
                end
                if (res_if.remaining !== oldest_expected.remaining) begin
                    $display("%0t: remaining mismatch: expected %0d, actual %0d",
                             $time, oldest_expected.remaining, res_if.remaining);
                    mismatches++;
                end
                if (res_if.completed !== oldest_expected.completed) begin
                    $display("%0t: completed mismatch: expected %0d, actual %0d",
                             $time, oldest_expected.completed, res_if.completed);
                    mismatches++;
                end
                case (oldest_expected.status)
                    tqs_pkg::STATUS_ADDED: n_added++;
                    tqs_pkg::STATUS_FULL:  n_full++;
                    tqs_pkg::STATUS_EMPTY: n_empty++;
                    default: begin
                        n_ran++;
                        if (oldest_expected.completed) n_done++;
                    end
                endcase
            end
        end
    end

    // Result-side backpressure: random stall bursts between ready runs
    initial begin
        int hold;
        hold = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (!quiet_run && $urandom_range(0, 3) == 0) begin
                res_if.ready <= 1'b0;
                hold = $urandom_range(0, 18);
            end else begin
                res_if.ready <= 1'b1;
                hold = $urandom_range(0, 29);
            end
        end
    end

    // Watchdog on cycles without any transaction
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (cmd_if.valid && cmd_if.ready) ||
                (res_if.valid && res_if.ready) || (cfg_if.valid && cfg_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: timeout, no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        cmd_if.valid    = 1'b0;
        cmd_if.command  = tqs_pkg::CMD_ADD;
        cmd_if.task_id  = '0;
        cmd_if.duration = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = tqs_pkg::CFG_POLICY;
        cfg_if.data     = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_and_limits();
        test_fill_to_capacity();
        test_shortest_first_ties();
        test_zero_quantum();
        test_random_traffic();
        test_quiet_tail();

        finish_pending();
        repeat (SETTLE) @(posedge i_clk);

        $display("Results checked: %0d added, %0d full, %0d ran (%0d completed), %0d empty",
                 n_added, n_full, n_ran, n_done, n_empty);
        $display("Register settings applied: %0d, both policies, quantum 0 through 65535",
                 n_settings);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
